// File: design/rwhp_pkg.sv
package rwhp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [7:0]  audio_byte;
        logic        format_valid;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
    } out_t;

    typedef enum logic [13:0] {
        PH_RIFF     = 14'b00000000000001,
        PH_RIFFLEN  = 14'b00000000000010,
        PH_WAVE     = 14'b00000000000100,
        PH_FTAG     = 14'b00000000001000,
        PH_FLEN     = 14'b00000000010000,
        PH_FSKIP    = 14'b00000000100000,
        PH_FMTBODY  = 14'b00000001000000,
        PH_FMTEXTRA = 14'b00000010000000,
        PH_DTAG     = 14'b00000100000000,
        PH_DLEN     = 14'b00001000000000,
        PH_DSKIP    = 14'b00010000000000,
        PH_AUDIO    = 14'b00100000000000,
        PH_ENDED    = 14'b01000000000000,
        PH_ERROR    = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  field_byte_index;
        logic [31:0] assembly_word;
        logic [31:0] chunk_tag;
        logic [31:0] bytes_left;
        logic [31:0] fmt_extra_bytes;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] data_length;
        logic [2:0]  error;
        logic        pad_pending;
        logic        fmt_latched;
    } state_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_AUDIO  = 2'd1;
    localparam logic [1:0] KIND_ENDED  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_RIFF    = 3'd1;
    localparam logic [2:0] ERR_BAD_WAVE    = 3'd2;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ERR_FMT_SHORT   = 3'd4;
    localparam logic [2:0] ERR_NOT_PCM     = 3'd5;
    localparam logic [2:0] ERR_EARLY_END   = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_FACT = 32'h66616374;
    localparam logic [31:0] TAG_LIST = 32'h4C495354;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [31:0] FMT_MIN_LEN = 32'd16;
    localparam logic [15:0] PCM_CODE    = 16'd1;

    localparam logic [3:0] POS_FORMAT   = 4'd1;
    localparam logic [3:0] POS_CHANNELS = 4'd3;
    localparam logic [3:0] POS_RATE     = 4'd7;
    localparam logic [3:0] POS_BITS     = 4'd15;

endpackage

// File: design/rwhp_step.sv
module rwhp_step (
    input  rwhp_pkg::state_t cur,
    input  rwhp_pkg::in_t    din,
    output rwhp_pkg::state_t nxt,
    output rwhp_pkg::out_t   res
);
    import rwhp_pkg::*;

    logic [31:0] tag_shift;
    logic [31:0] asm_shift;
    logic [1:0]  idx_inc;
    logic        field_done;
    logic [31:0] left_dec;
    logic [31:0] extra_dec;
    logic [3:0]  pos;
    logic [1:0]  kind;
    logic [7:0]  abyte;

    always_comb begin
        nxt        = cur;
        kind       = KIND_HEADER;
        abyte      = 8'd0;
        tag_shift  = {cur.chunk_tag[23:0], din.in_byte};
        asm_shift  = {din.in_byte, cur.assembly_word[31:8]};
        idx_inc    = cur.field_byte_index + 2'd1;
        field_done = (idx_inc == 2'd0);
        left_dec   = cur.bytes_left - 32'd1;
        extra_dec  = cur.fmt_extra_bytes - 32'd1;
        pos        = 4'd0 - cur.bytes_left[3:0];

        if (cur.phase == PH_ENDED) begin
            kind = KIND_ENDED;
        end else if (cur.phase != PH_ERROR) begin
            if (din.stream_end) begin
                nxt.error = ERR_EARLY_END;
                nxt.phase = PH_ERROR;
            end else begin
                case (cur.phase)
                    PH_RIFF, PH_WAVE, PH_FTAG, PH_DTAG: begin
                        nxt.chunk_tag        = tag_shift;
                        nxt.field_byte_index = idx_inc;
                        if (field_done) begin
                            if (cur.phase == PH_RIFF) begin
                                if (tag_shift == TAG_RIFF) begin
                                    nxt.phase = PH_RIFFLEN;
                                end else begin
                                    nxt.error = ERR_BAD_RIFF;
                                    nxt.phase = PH_ERROR;
                                end
                            end else if (cur.phase == PH_WAVE) begin
                                if (tag_shift == TAG_WAVE) begin
                                    nxt.phase = PH_FTAG;
                                end else begin
                                    nxt.error = ERR_BAD_WAVE;
                                    nxt.phase = PH_ERROR;
                                end
                            end else if (cur.phase == PH_FTAG) begin
                                if (tag_shift == TAG_FMT || tag_shift == TAG_FACT
                                        || tag_shift == TAG_LIST) begin
                                    nxt.phase = PH_FLEN;
                                end else begin
                                    nxt.error = ERR_UNSUPPORTED;
                                    nxt.phase = PH_ERROR;
                                end
                            end else begin
                                nxt.phase = PH_DLEN;
                            end
                        end
                    end
                    PH_RIFFLEN: begin
                        nxt.assembly_word    = asm_shift;
                        nxt.field_byte_index = idx_inc;
                        if (field_done) begin
                            nxt.phase = PH_WAVE;
                        end
                    end
                    PH_FLEN: begin
                        nxt.assembly_word    = asm_shift;
                        nxt.field_byte_index = idx_inc;
                        if (field_done) begin
                            if (cur.chunk_tag == TAG_FMT) begin
                                if (asm_shift < FMT_MIN_LEN) begin
                                    nxt.error = ERR_FMT_SHORT;
                                    nxt.phase = PH_ERROR;
                                end else begin
                                    nxt.fmt_extra_bytes = asm_shift - FMT_MIN_LEN;
                                    nxt.pad_pending     = asm_shift[0];
                                    nxt.bytes_left      = FMT_MIN_LEN;
                                    nxt.phase           = PH_FMTBODY;
                                end
                            end else begin
                                nxt.bytes_left  = asm_shift;
                                nxt.pad_pending = asm_shift[0];
                                nxt.phase = (asm_shift != 32'd0) ? PH_FSKIP : PH_FTAG;
                            end
                        end
                    end
                    PH_DLEN: begin
                        nxt.assembly_word    = asm_shift;
                        nxt.field_byte_index = idx_inc;
                        if (field_done) begin
                            nxt.bytes_left = asm_shift;
                            if (cur.chunk_tag == TAG_DATA) begin
                                nxt.data_length = asm_shift;
                                nxt.phase = (asm_shift != 32'd0) ? PH_AUDIO : PH_ENDED;
                            end else begin
                                nxt.pad_pending = asm_shift[0];
                                nxt.phase = (asm_shift != 32'd0) ? PH_DSKIP : PH_DTAG;
                            end
                        end
                    end
                    PH_FSKIP, PH_DSKIP: begin
                        if (cur.bytes_left != 32'd0) begin
                            nxt.bytes_left = left_dec;
                            if (left_dec == 32'd0 && !cur.pad_pending) begin
                                nxt.phase = (cur.phase == PH_FSKIP) ? PH_FTAG : PH_DTAG;
                            end
                        end else begin
                            nxt.pad_pending = 1'b0;
                            nxt.phase = (cur.phase == PH_FSKIP) ? PH_FTAG : PH_DTAG;
                        end
                    end
                    PH_FMTEXTRA: begin
                        if (cur.fmt_extra_bytes != 32'd0) begin
                            nxt.fmt_extra_bytes = extra_dec;
                            if (extra_dec == 32'd0 && !cur.pad_pending) begin
                                nxt.phase = PH_DTAG;
                            end
                        end else begin
                            nxt.pad_pending = 1'b0;
                            nxt.phase       = PH_DTAG;
                        end
                    end
                    PH_FMTBODY: begin
                        nxt.assembly_word    = asm_shift;
                        nxt.field_byte_index = 2'd0;
                        nxt.bytes_left       = left_dec;
                        if (pos == POS_FORMAT) begin
                            if (asm_shift[31:16] != PCM_CODE) begin
                                nxt.error = ERR_NOT_PCM;
                                nxt.phase = PH_ERROR;
                            end
                        end else if (pos == POS_CHANNELS) begin
                            nxt.channels = asm_shift[31:16];
                        end else if (pos == POS_RATE) begin
                            nxt.rate = asm_shift;
                        end else if (pos == POS_BITS) begin
                            nxt.bits        = asm_shift[31:16];
                            nxt.fmt_latched = 1'b1;
                            nxt.phase = (cur.fmt_extra_bytes != 32'd0 || cur.pad_pending)
                                ? PH_FMTEXTRA : PH_DTAG;
                        end
                    end
                    PH_AUDIO: begin
                        kind           = KIND_AUDIO;
                        abyte          = din.in_byte;
                        nxt.bytes_left = left_dec;
                        if (left_dec == 32'd0) begin
                            nxt.phase = PH_ENDED;
                        end
                    end
                    default: begin
                        nxt.error = ERR_NONE;
                        nxt.phase = PH_ERROR;
                    end
                endcase
            end
        end

        if (nxt.phase == PH_ERROR) begin
            kind = KIND_ERROR;
        end

        res.kind          = kind;
        res.error_code    = (kind == KIND_ERROR) ? nxt.error : ERR_NONE;
        res.audio_byte    = abyte;
        res.format_valid  = nxt.fmt_latched;
        res.channel_count = nxt.fmt_latched ? nxt.channels : 16'd0;
        res.sample_rate   = nxt.fmt_latched ? nxt.rate : 32'd0;
        res.sample_bits   = nxt.fmt_latched ? nxt.bits : 16'd0;
        res.data_length   = nxt.data_length;
    end

endmodule

// File: design/riff_wave_header_parser_unit.sv
// Channel   Ports                          Word
// input     s_valid, s_ready, s_data       one file byte and the end-of-stream flag
// result    m_valid, m_ready, m_data       one result with the latched format fields
//
// Every accepted byte produces exactly one result word, registered and valid from the cycle after the accept.
// A new byte is accepted every cycle while the result register is empty or being taken.
// The parse state and the result register update together in the accept cycle.
// A stall on m_ready holds the result and drops s_ready until it is taken.
// Synchronous reset returns the parser to the RIFF magic check with no format latched.
module riff_wave_header_parser_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rwhp_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output rwhp_pkg::out_t  m_data
);
    import rwhp_pkg::*;

    localparam state_t STATE_RESET = '{
        phase:            PH_RIFF,
        field_byte_index: 2'd0,
        assembly_word:    32'd0,
        chunk_tag:        32'd0,
        bytes_left:       32'd0,
        fmt_extra_bytes:  32'd0,
        channels:         16'd0,
        rate:             32'd0,
        bits:             16'd0,
        data_length:      32'd0,
        error:            ERR_NONE,
        pad_pending:      1'b0,
        fmt_latched:      1'b0
    };

    state_t state_reg;
    state_t state_next;
    out_t   result_next;
    out_t   m_data_reg;
    logic   m_valid_reg;
    logic   accept;

    rwhp_step u_step (
        .cur (state_reg),
        .din (s_data),
        .nxt (state_next),
        .res (result_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result_next;
        end
    end

endmodule
